[design/bgf_pkg.sv]
`timescale 1ns / 1ps

package bgf_pkg;

    localparam int SMOOTH_W   = 13;
    localparam int RAW_W      = 16;
    localparam int PCT_W      = 7;
    localparam int LVL_W      = 3;
    localparam int MARGIN_W   = 4;
    localparam int IDX_W      = 4;
    localparam int NUM_W      = 12;
    localparam int DEN_W      = 9;
    localparam int CNT_W      = 4;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [RAW_W-1:0]    MV_CLAMP_HI = 16'd4400;
    localparam logic [RAW_W-1:0]    MV_CLAMP_LO = 16'd2700;
    localparam logic [RAW_W-1:0]    PCT_CLAMP   = 16'd100;
    localparam logic [SMOOTH_W-1:0] CURVE_TOP   = 13'd4200;
    localparam logic [SMOOTH_W-1:0] CURVE_BOT   = 13'd3000;
    localparam logic [PCT_W-1:0]    PCT_FULL    = 7'd100;
    localparam logic [LVL_W-1:0]    LVL_MIN     = 3'd1;
    localparam logic [LVL_W-1:0]    LVL_MAX     = 3'd5;
    localparam logic [MARGIN_W-1:0] MARGIN_RST  = 4'd3;

    typedef enum logic [0:0] {
        REG_SOURCE_MODE = 1'b0,
        REG_HYST_MARGIN = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic                source_mode;
        logic [MARGIN_W-1:0] hysteresis_margin;
    } cfg_t;

    // discharge curve, index 0 is full charge
    function automatic logic [SMOOTH_W-1:0] curve_mv(input logic [IDX_W-1:0] i);
        logic [SMOOTH_W-1:0] r;
        case (i)
            4'd0:    r = 13'd4200;
            4'd1:    r = 13'd4060;
            4'd2:    r = 13'd3980;
            4'd3:    r = 13'd3920;
            4'd4:    r = 13'd3870;
            4'd5:    r = 13'd3820;
            4'd6:    r = 13'd3790;
            4'd7:    r = 13'd3770;
            4'd8:    r = 13'd3740;
            4'd9:    r = 13'd3680;
            4'd10:   r = 13'd3450;
            default: r = 13'd3000;
        endcase
        return r;
    endfunction

    function automatic logic [PCT_W-1:0] curve_pc(input logic [IDX_W-1:0] i);
        logic [PCT_W-1:0] r;
        case (i)
            4'd0:    r = 7'd100;
            4'd1:    r = 7'd90;
            4'd2:    r = 7'd80;
            4'd3:    r = 7'd70;
            4'd4:    r = 7'd60;
            4'd5:    r = 7'd50;
            4'd6:    r = 7'd40;
            4'd7:    r = 7'd30;
            4'd8:    r = 7'd20;
            4'd9:    r = 7'd10;
            4'd10:   r = 7'd5;
            default: r = 7'd0;
        endcase
        return r;
    endfunction

    function automatic logic [PCT_W-1:0] level_thr(input logic [1:0] i);
        logic [PCT_W-1:0] r;
        case (i)
            2'd0:    r = 7'd20;
            2'd1:    r = 7'd40;
            2'd2:    r = 7'd60;
            default: r = 7'd80;
        endcase
        return r;
    endfunction

endpackage

[design/battery_gauge_filter.sv]
`timescale 1ns / 1ps

// Battery state-of-charge filter. One input beat carries one reading
// (read_failed, raw_value); one output beat (percent, level) answers it.
// raw_value is a gauge percentage or ADC millivolts, picked by source_mode.
// Both channels use valid/stall; registers sit on an APB port (0x0 mode,
// 0x4 hysteresis margin) and are to be written only while the block is idle,
// which the block itself does not enforce. in_stall is high while a reading
// is being worked on, so one reading is in flight at a time. A failed read
// goes straight to the output register. Percent mode clamps, smooths and
// converts, then does a level walk of one step a cycle. Millivolt mode, for
// a value between the curve ends, adds a serial segment search over the
// 12-point curve and the 12-step shift-subtract divide of the interpolation
// before the level walk. The next input beat is taken only once a result
// is loaded, so a new reading is not accepted before the last one is done.
// Results sit in an output register; a stalled result holds, and the next
// reading is accepted meanwhile but its result waits for that register.
// Reset clears the filter: percent reads 0 and level reads 1 until the first
// good reading, which primes the filter and walks the level up from 1 with
// no hysteresis margin.
module battery_gauge_filter
    import bgf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  read_failed,
    input  logic [RAW_W-1:0]      raw_value,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [PCT_W-1:0]      percent,
    output logic [LVL_W-1:0]      level,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLAMP,
        ST_SMOOTH,
        ST_CONV,
        ST_SEARCH,
        ST_DIV,
        ST_FIN,
        ST_LEVEL,
        ST_DONE
    } state_t;

    cfg_t cfg;

    state_t              state_reg,   state_next;
    logic [RAW_W-1:0]    raw_reg,     raw_next;
    logic [SMOOTH_W-1:0] target_reg,  target_next;
    logic [SMOOTH_W-1:0] smooth_reg,  smooth_next;
    logic                primed_reg,  primed_next;
    logic                first_reg,   first_next;
    logic [PCT_W-1:0]    pct_reg,     pct_next;
    logic [LVL_W-1:0]    lvl_reg,     lvl_next;
    logic [IDX_W-1:0]    idx_reg,     idx_next;
    logic [NUM_W-1:0]    num_reg,     num_next;
    logic [DEN_W-1:0]    den_reg,     den_next;
    logic [DEN_W:0]      rem_reg,     rem_next;
    logic [NUM_W-1:0]    quo_reg,     quo_next;
    logic [CNT_W-1:0]    cnt_reg,     cnt_next;
    logic                out_vld_reg, out_vld_next;
    logic [PCT_W-1:0]    out_pct_reg, out_pct_next;
    logic [LVL_W-1:0]    out_lvl_reg, out_lvl_next;

    // clamp
    logic [SMOOTH_W-1:0] clamped;
    // smoothing step
    logic signed [SMOOTH_W:0] diff;
    logic [SMOOTH_W:0]        mag;
    logic [SMOOTH_W:0]        step;
    logic [SMOOTH_W-1:0]      stepped;
    // interpolation
    logic [IDX_W-1:0]    idx_inc;
    logic [SMOOTH_W-1:0] seg_hi;
    logic [SMOOTH_W-1:0] seg_lo;
    logic [SMOOTH_W-1:0] mv_off;
    logic [SMOOTH_W-1:0] seg_w;
    logic [PCT_W-1:0]    pc_span;
    logic [DEN_W+3:0]    prod;
    logic [DEN_W:0]      rem_shift;
    logic                rem_ge;
    // level walk
    logic [MARGIN_W-1:0] margin;
    logic [LVL_W-1:0]    lvl_m1;
    logic [LVL_W-1:0]    lvl_m2;
    logic [PCT_W:0]      thr_up;
    logic [PCT_W:0]      pct_lo;
    logic                go_up;
    logic                go_down;

    bgf_apb u_apb (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    always_comb
    begin
        if (cfg.source_mode)
        begin
            if (raw_reg > MV_CLAMP_HI)
                clamped = MV_CLAMP_HI[SMOOTH_W-1:0];
            else if (raw_reg < MV_CLAMP_LO)
                clamped = MV_CLAMP_LO[SMOOTH_W-1:0];
            else
                clamped = raw_reg[SMOOTH_W-1:0];
        end
        else
        begin
            if (raw_reg > PCT_CLAMP)
                clamped = PCT_CLAMP[SMOOTH_W-1:0];
            else
                clamped = raw_reg[SMOOTH_W-1:0];
        end
    end

    // step toward target: |diff| / 4 or / 8, truncated, at least one
    always_comb
    begin
        diff = $signed({1'b0, target_reg}) - $signed({1'b0, smooth_reg});
        mag  = diff[SMOOTH_W] ? (~diff + 1'b1) : diff;
        step = cfg.source_mode ? (mag >> 3) : (mag >> 2);
        if (step == '0 && diff != '0)
            step = {{SMOOTH_W{1'b0}}, 1'b1};
        stepped = diff[SMOOTH_W] ? (smooth_reg - step[SMOOTH_W-1:0])
                                 : (smooth_reg + step[SMOOTH_W-1:0]);
    end

    always_comb
    begin
        idx_inc   = idx_reg + 4'd1;
        seg_hi    = curve_mv(idx_reg);
        seg_lo    = curve_mv(idx_inc);
        mv_off    = smooth_reg - seg_lo;
        seg_w     = seg_hi - seg_lo;
        pc_span   = curve_pc(idx_reg) - curve_pc(idx_inc);
        prod      = mv_off[DEN_W-1:0] * pc_span[3:0];
        rem_shift = {rem_reg[DEN_W-1:0], num_reg[NUM_W-1]};
        rem_ge    = rem_shift >= {1'b0, den_reg};
    end

    always_comb
    begin
        margin  = first_reg ? '0 : cfg.hysteresis_margin;
        lvl_m1  = lvl_reg - 3'd1;
        lvl_m2  = lvl_reg - 3'd2;
        thr_up  = {1'b0, level_thr(lvl_m1[1:0])} + {4'b0, margin};
        pct_lo  = {1'b0, pct_reg} + {4'b0, margin};
        go_up   = (lvl_reg < LVL_MAX) && ({1'b0, pct_reg} >= thr_up);
        go_down = (lvl_reg > LVL_MIN) && (pct_lo < {1'b0, level_thr(lvl_m2[1:0])});
    end

    always_comb
    begin
        state_next   = state_reg;
        raw_next     = raw_reg;
        target_next  = target_reg;
        smooth_next  = smooth_reg;
        primed_next  = primed_reg;
        first_next   = first_reg;
        pct_next     = pct_reg;
        lvl_next     = lvl_reg;
        idx_next     = idx_reg;
        num_next     = num_reg;
        den_next     = den_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        cnt_next     = cnt_reg;
        out_vld_next = out_vld_reg;
        out_pct_next = out_pct_reg;
        out_lvl_next = out_lvl_reg;

        if (out_vld_reg && !out_stall)
            out_vld_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    raw_next   = raw_value;
                    state_next = read_failed ? ST_DONE : ST_CLAMP;
                end
            end
            ST_CLAMP:
            begin
                target_next = clamped;
                if (!primed_reg)
                begin
                    smooth_next = clamped;
                    primed_next = 1'b1;
                    first_next  = 1'b1;
                    state_next  = ST_CONV;
                end
                else
                begin
                    first_next = 1'b0;
                    state_next = ST_SMOOTH;
                end
            end
            ST_SMOOTH:
            begin
                smooth_next = stepped;
                state_next  = ST_CONV;
            end
            ST_CONV:
            begin
                lvl_next = (lvl_reg == '0) ? LVL_MIN : lvl_reg;
                if (!cfg.source_mode)
                begin
                    pct_next   = (smooth_reg > {6'b0, PCT_FULL}) ? PCT_FULL
                                                                  : smooth_reg[PCT_W-1:0];
                    state_next = ST_LEVEL;
                end
                else if (smooth_reg >= CURVE_TOP)
                begin
                    pct_next   = PCT_FULL;
                    state_next = ST_LEVEL;
                end
                else if (smooth_reg <= CURVE_BOT)
                begin
                    pct_next   = '0;
                    state_next = ST_LEVEL;
                end
                else
                begin
                    idx_next   = '0;
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                // walk down the curve until the segment's low end is reached
                if (smooth_reg >= seg_lo)
                begin
                    num_next   = prod[NUM_W-1:0];
                    den_next   = seg_w[DEN_W-1:0];
                    rem_next   = '0;
                    quo_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
                else
                begin
                    idx_next = idx_inc;
                end
            end
            ST_DIV:
            begin
                rem_next = rem_ge ? (rem_shift - {1'b0, den_reg}) : rem_shift;
                quo_next = {quo_reg[NUM_W-2:0], rem_ge};
                num_next = {num_reg[NUM_W-2:0], 1'b0};
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == CNT_W'(NUM_W - 1))
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                pct_next   = curve_pc(idx_inc) + quo_reg[PCT_W-1:0];
                state_next = ST_LEVEL;
            end
            ST_LEVEL:
            begin
                if (go_up)
                    lvl_next = lvl_reg + 3'd1;
                else if (go_down)
                    lvl_next = lvl_reg - 3'd1;
                else
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_vld_reg || !out_stall)
                begin
                    out_vld_next = 1'b1;
                    out_pct_next = pct_reg;
                    out_lvl_next = (lvl_reg == '0) ? LVL_MIN : lvl_reg;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            raw_reg     <= '0;
            target_reg  <= '0;
            smooth_reg  <= '0;
            primed_reg  <= 1'b0;
            first_reg   <= 1'b0;
            pct_reg     <= '0;
            lvl_reg     <= '0;
            idx_reg     <= '0;
            num_reg     <= '0;
            den_reg     <= '0;
            rem_reg     <= '0;
            quo_reg     <= '0;
            cnt_reg     <= '0;
            out_vld_reg <= 1'b0;
            out_pct_reg <= '0;
            out_lvl_reg <= LVL_MIN;
        end
        else
        begin
            state_reg   <= state_next;
            raw_reg     <= raw_next;
            target_reg  <= target_next;
            smooth_reg  <= smooth_next;
            primed_reg  <= primed_next;
            first_reg   <= first_next;
            pct_reg     <= pct_next;
            lvl_reg     <= lvl_next;
            idx_reg     <= idx_next;
            num_reg     <= num_next;
            den_reg     <= den_next;
            rem_reg     <= rem_next;
            quo_reg     <= quo_next;
            cnt_reg     <= cnt_next;
            out_vld_reg <= out_vld_next;
            out_pct_reg <= out_pct_next;
            out_lvl_reg <= out_lvl_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_vld_reg;
    assign percent   = out_pct_reg;
    assign level     = out_lvl_reg;

endmodule

[design/bgf_apb.sv]
`timescale 1ns / 1ps

module bgf_apb
    import bgf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    logic                source_mode_reg;
    logic [MARGIN_W-1:0] margin_reg;
    logic                wr_en;
    reg_idx_t            reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = reg_idx_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_mode_reg <= 1'b0;
            margin_reg      <= MARGIN_RST;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_SOURCE_MODE: source_mode_reg <= pwdata[0];
                REG_HYST_MARGIN: margin_reg      <= pwdata[MARGIN_W-1:0];
                default:         margin_reg      <= margin_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_SOURCE_MODE: prdata = {{(APB_DATA_W-1){1'b0}}, source_mode_reg};
            REG_HYST_MARGIN: prdata = {{(APB_DATA_W-MARGIN_W){1'b0}}, margin_reg};
            default:         prdata = '0;
        endcase
    end

    assign cfg.source_mode       = source_mode_reg;
    assign cfg.hysteresis_margin = margin_reg;

endmodule
